### rtl/emp_pkg.sv
// Shared types and constants of the emergency message producer.
// Used by every module of the block but emp_ram; depends on nothing else.
package emp_pkg;

   localparam int HISTORY_DEPTH = 10;
   localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int POS_W = CNT_W + 1;

   localparam int MFG_W = 40;
   localparam int CODE_W = 16;
   localparam int HIST_W = CODE_W + MFG_W;
   localparam int MFG_BYTES = 5;

   localparam logic [10:0] EMCY_BASE_ID = 11'h080;
   localparam logic [7:0] ALARM_ERR_REG = 8'h01;

   localparam logic [1:0] OP_ALARM = 2'd0;
   localparam logic [1:0] OP_RESET_MSG = 2'd1;
   localparam logic [1:0] OP_HIST_READ = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INHIBIT = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] error_code_in;
      logic [39:0] mfg_bytes_in;
      logic [7:0]  mfg_length;
      logic [7:0]  history_index;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [10:0] frame_id;
      logic [15:0] error_code_out;
      logic [7:0]  err_reg;
      logic [39:0] mfg_bytes_out;
      logic        found;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic alarm;
      logic reset_msg;
      logic tick;
      logic hist_miss;
      logic hist_emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       inhibited;
      logic       idx_beyond;
   } sts_type;

endpackage

### rtl/emp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the alarm history; no package dependency.
module emp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/emp_ctrl.sv
// Controller state machine of the emergency message producer.
// Depends on emp_pkg for the command and status types and operation codes.
module emp_ctrl import emp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (sts.operation)
               OP_ALARM: begin
                  cmd.alarm = !sts.inhibited;
               end
               OP_RESET_MSG: begin
                  cmd.reset_msg = 1'b1;
               end
               OP_HIST_READ: begin
                  if (sts.idx_beyond) begin
                     cmd.hist_miss = 1'b1;
                  end else begin
                     // The history RAM has a registered read port, so the entry is returned in ST_READ.
                     state_in = ST_READ;
                  end
               end
               OP_TICK: begin
                  cmd.tick = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            cmd.hist_emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/emp_dp.sv
// Datapath of the emergency message producer: request, timing and history state.
// Depends on emp_pkg and on emp_ram for the alarm history.
module emp_dp import emp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data
);

   req_type            req_ff;
   logic [6:0]         node_ff;
   logic [31:0]        inhibit_ff;
   logic [31:0]        clock_ms_ff;
   logic [31:0]        last_alarm_ff;
   logic [HIST_AW-1:0] slot_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [31:0]        elapsed;
   logic [10:0]        frame_id;
   logic [MFG_W-1:0]   mfg_masked;
   logic [CNT_W-1:0]   idx_narrow;
   logic [POS_W-1:0]   pos_sum;
   logic [POS_W-1:0]   pos_wrapped;
   logic [HIST_AW-1:0] rd_addr;
   logic [HIST_W-1:0]  rd_data;

   assign elapsed = clock_ms_ff - last_alarm_ff;
   assign frame_id = EMCY_BASE_ID + {4'b0000, node_ff};

   always_comb begin
      for (int i = 0; i < MFG_BYTES; i++) begin
         mfg_masked[8*i +: 8] = (req_ff.mfg_length > 8'(i)) ?
                                req_ff.mfg_bytes_in[8*i +: 8] : 8'h00;
      end
   end

   assign sts.operation = req_ff.operation;
   assign sts.inhibited = (elapsed < inhibit_ff);
   assign sts.idx_beyond = (req_ff.history_index >= 8'(count_ff));

   // Entry idx places back from the newest; only used when idx is below the count.
   assign idx_narrow = req_ff.history_index[CNT_W-1:0];
   assign pos_sum = POS_W'(slot_ff) + POS_W'(HISTORY_DEPTH - 1) - POS_W'(idx_narrow);
   assign pos_wrapped = (pos_sum >= POS_W'(HISTORY_DEPTH)) ?
                        (pos_sum - POS_W'(HISTORY_DEPTH)) : pos_sum;
   assign rd_addr = pos_wrapped[HIST_AW-1:0];

   emp_ram #(
      .WIDTH (HIST_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.alarm),
      .wr_addr (slot_ff),
      .wr_data ({req_ff.error_code_in, mfg_masked}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         inhibit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_ID: node_ff <= csr_wdata[6:0];
            CSR_INHIBIT: inhibit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff <= '0;
         last_alarm_ff <= '0;
         slot_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.tick) begin
            clock_ms_ff <= clock_ms_ff + 32'd1;
         end
         if (cmd.alarm) begin
            last_alarm_ff <= clock_ms_ff;
            slot_ff <= (slot_ff == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.alarm | cmd.reset_msg | cmd.hist_miss | cmd.hist_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alarm) begin
         rsp_ff <= '{result_kind: 1'b0, frame_id: frame_id,
                     error_code_out: req_ff.error_code_in,
                     err_reg: ALARM_ERR_REG, mfg_bytes_out: mfg_masked,
                     found: 1'b1};
      end else if (cmd.reset_msg) begin
         rsp_ff <= '{result_kind: 1'b0, frame_id: frame_id, error_code_out: '0,
                     err_reg: '0, mfg_bytes_out: '0, found: 1'b1};
      end else if (cmd.hist_miss) begin
         rsp_ff <= '{result_kind: 1'b1, frame_id: '0, error_code_out: '0,
                     err_reg: '0, mfg_bytes_out: '0, found: 1'b0};
      end else if (cmd.hist_emit) begin
         rsp_ff <= '{result_kind: 1'b1, frame_id: '0,
                     error_code_out: rd_data[HIST_W-1 -: CODE_W],
                     err_reg: '0, mfg_bytes_out: rd_data[MFG_W-1:0],
                     found: 1'b1};
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### rtl/emergency_message_producer.sv
// Top level of the emergency message producer: controller plus datapath.
// Depends on emp_pkg, emp_ctrl and emp_dp.
//
// A command is taken when start is high while busy is low. Alarm, reset-message
// and tick commands, and history reads that miss, keep busy high through the
// execute step after acceptance; a history read that finds its entry also keeps
// busy high through a read step, because the history RAM has a registered read
// port. A result appears on rsp_data with rsp_strobe high for exactly one cycle,
// the cycle after the execute step (or after the RAM read), and the receiver
// must take it then. Suppressed alarms and ticks give no result. Configuration
// writes are taken while busy is low.
module emergency_message_producer import emp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   emp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   assign csr_ready = !busy;

   emp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/emp_checker.sv
// Port-level checks of the emergency message producer, bound to the top level.
// Depends on emp_pkg for the payload types.
module emp_port_checks import emp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // After a result the controller must pass through ST_IDLE and ST_EXEC again, so results never come back to back.
   a_no_adjacent_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in adjacent cycles");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // Emergency frames always carry the base identifier in their upper bits and are always valid.
   a_frame_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.result_kind) |->
      (rsp_data.found && rsp_data.frame_id[10:7] == 4'b0001))
      else $error("malformed emergency frame");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.result_kind && !rsp_data.found) |->
      (rsp_data.frame_id == '0 && rsp_data.error_code_out == '0 &&
       rsp_data.err_reg == '0 && rsp_data.mfg_bytes_out == '0))
      else $error("history miss reply carries data");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

bind emergency_message_producer emp_port_checks u_emp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
